>>> sv/dwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dwd_pkg;

  localparam int unsigned EntryW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    ActPushBack = 2'd0,
    ActPopFront = 2'd1,
    ActPopBack  = 2'd2,
    ActDelete   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [EntryW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [EntryW-1:0] removed_value;
    logic [CountW-1:0]        entry_count;
  } res_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic                     take;
    action_e                  action;
    logic [EntryW-1:0]        value;
    logic                     shift_all;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/dwd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dwd_cell import dwd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              prev_valid_i,
  input  logic [EntryW-1:0] next_data_i,
  input  logic              next_valid_i,
  input  logic              hit_i,
  output logic              hit_o,
  output logic [EntryW-1:0] data_o,
  output logic              valid_o,
  output logic              last_o
);

  logic [EntryW-1:0] data_q, data_d;
  logic              valid_q, valid_d;
  logic              match;

  // Match chain: set from the first matching valid entry onwards
  assign match  = valid_q && (data_q == ctrl_i.value);
  assign hit_o  = hit_i | match;
  assign last_o = valid_q & ~next_valid_i;

  // Next contents of this cell
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.take) begin
      unique case (ctrl_i.action)
        ActPushBack: begin
          if (!valid_q && prev_valid_i) begin
            data_d  = ctrl_i.value;
            valid_d = 1'b1;
          end
        end
        ActPopFront: begin
          if (ctrl_i.shift_all) begin
            data_d  = next_data_i;
            valid_d = next_valid_i;
          end
        end
        ActPopBack: begin
          if (last_o) begin
            valid_d = 1'b0;
          end
        end
        ActDelete: begin
          // this cell and every later one take their neighbour's entry
          if (hit_o) begin
            data_d  = next_data_i;
            valid_d = next_valid_i;
          end
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

>>> sv/deque_with_value_delete.sv
// The result strobe valid_o rises the cycle after start_i is taken.
// Throughput: one command per cycle, busy_o stays low; every cell of the row
// compares and shifts its entry in the same cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_ni low, asynchronous) empties the queue; entry data is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module deque_with_value_delete import dwd_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  cmd_t cmd_i,
  output logic valid_o,
  output res_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]   count_q, count_d;
  logic              valid_q;
  res_t              res_q, res_d;
  logic              take;
  cell_ctrl_t        ctrl;

  logic [EntryW-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_last;
  logic [DEPTH:0]    hit_chain;
  logic [DEPTH-1:0]  prev_valid;
  logic [EntryW-1:0] back_value;

  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;

  // Command broadcast to the row
  always_comb begin
    ctrl.take      = take;
    ctrl.action    = action_e'(cmd_i.action);
    ctrl.value     = cmd_i.value;
    ctrl.shift_all = cell_valid[0];
  end

  assign hit_chain[0] = 1'b0;

  // Row of cells, front at cell 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [EntryW-1:0] nxt_data;
    logic              nxt_valid;
    if (g == DEPTH - 1) begin : g_end
      assign nxt_data  = cell_data[g];
      assign nxt_valid = 1'b0;
    end else begin : g_mid
      assign nxt_data  = cell_data[g+1];
      assign nxt_valid = cell_valid[g+1];
    end
    if (g == 0) begin : g_head
      assign prev_valid[g] = 1'b1;
    end else begin : g_body
      assign prev_valid[g] = cell_valid[g-1];
    end

    dwd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid[g]),
      .next_data_i  (nxt_data),
      .next_valid_i (nxt_valid),
      .hit_i        (hit_chain[g]),
      .hit_o        (hit_chain[g+1]),
      .data_o       (cell_data[g]),
      .valid_o      (cell_valid[g]),
      .last_o       (cell_last[g])
    );
  end

  // Back entry: exactly one cell is last when the queue holds anything
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_data[i] & {EntryW{cell_last[i]}});
    end
  end

  // Result and count update
  always_comb begin
    count_d             = count_q;
    res_d.status        = StOk;
    res_d.removed_value = '0;
    unique case (action_e'(cmd_i.action))
      ActPushBack: begin
        if (count_q == CntW'(DEPTH)) begin
          res_d.status = StFull;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      ActPopFront: begin
        if (count_q == '0) begin
          res_d.status = StEmpty;
        end else begin
          res_d.removed_value = cell_data[0];
          count_d             = count_q - CntW'(1);
        end
      end
      ActPopBack: begin
        if (count_q == '0) begin
          res_d.status = StEmpty;
        end else begin
          res_d.removed_value = back_value;
          count_d             = count_q - CntW'(1);
        end
      end
      ActDelete: begin
        if (hit_chain[DEPTH]) begin
          res_d.removed_value = cmd_i.value;
          count_d             = count_q - CntW'(1);
        end else begin
          res_d.status = StNotFound;
        end
      end
      default: begin
        res_d.status = StOk;
      end
    endcase
    // count field is the occupancy masked to its width
    res_d.entry_count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= take;
      if (take) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

>>> tb/sv/deque_with_value_delete_checker.sv
`timescale 1ns / 1ps
module deque_with_value_delete_checker import dwd_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  cmd_t        cmd_i,
  input  logic        valid_i,
  input  res_t        res_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  // Shadow of the queue contents, front at index 0
  logic signed [EntryW-1:0] held_q[$];
  // Results still owed by the block, oldest first
  res_t                     owed_q[$];
  res_t                     oldest;
  int unsigned              mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  // Apply one command to the shadow queue and return the result it should give
  function automatic res_t apply_command(cmd_t c);
    res_t        r;
    int unsigned idx;
    logic        found;
    r = '0;
    found = 1'b0;
    r.status = StOk;
    case (c.action)
      ActPushBack: begin
        if (held_q.size() >= DEPTH) r.status = StFull;
        else held_q.push_back(c.value);
      end
      ActPopFront: begin
        if (held_q.size() == 0) r.status = StEmpty;
        else r.removed_value = held_q.pop_front();
      end
      ActPopBack: begin
        if (held_q.size() == 0) r.status = StEmpty;
        else r.removed_value = held_q.pop_back();
      end
      default: begin
        // first match from the front; later entries close the gap
        r.status = StNotFound;
        for (idx = 0; idx < held_q.size(); idx++) begin
          if (!found && held_q[idx] == c.value) begin
            found = 1'b1;
            r.removed_value = held_q[idx];
            held_q.delete(idx);
            r.status = StOk;
          end
        end
      end
    endcase
    r.entry_count = CountW'(held_q.size());
    return r;
  endfunction

  // Predict on each command transfer, then compare each result strobe
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q.delete();
      owed_q.delete();
      pending_o <= 0;
    end else begin
      if (start_i && !busy_i) owed_q.push_back(apply_command(cmd_i));
      if (valid_i) begin
        if (owed_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result: status %0d removed %0d count %0d", $realtime,
                     res_i.status, res_i.removed_value, res_i.entry_count);
        end else begin
          oldest = owed_q.pop_front();
          if (res_i.status !== oldest.status ||
              res_i.removed_value !== oldest.removed_value ||
              res_i.entry_count !== oldest.entry_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: result mismatch: expected status %0d removed %0d count %0d,",
                        " got status %0d removed %0d count %0d"},
                       $realtime, oldest.status, oldest.removed_value, oldest.entry_count,
                       res_i.status, res_i.removed_value, res_i.entry_count);
          end
        end
      end
      pending_o <= owed_q.size();
    end
  end

endmodule

>>> tb/sv/deque_with_value_delete_tb.sv
`timescale 1ns / 1ps
module deque_with_value_delete_tb;
  import dwd_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned RandomCmds  = 650;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  cmd_t        cmd_i   = '0;
  logic        busy_o;
  logic        valid_o;
  res_t        res_o;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles  = 0;
  logic        burst_mode = 1'b0;

  always #5 clk_i = ~clk_i;

  deque_with_value_delete #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_i  (cmd_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  deque_with_value_delete_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .cmd_i       (cmd_i),
    .valid_i     (valid_o),
    .res_i       (res_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive one command from a falling edge and hold it until the transfer; returns at a
  // falling edge with start still high, so a back-to-back command needs no extra edge
  task automatic issue(input action_e act, input logic signed [EntryW-1:0] val);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i.action <= act;
    cmd_i.value  <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned              n;
    int unsigned              k;
    int unsigned              push_pct;
    int unsigned              sel;
    logic signed [EntryW-1:0] val;
    action_e                  act;

    push_pct = 50;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-store cases, field extremes, first-match delete, full store
    issue(ActPopFront, '1);
    issue(ActPopBack, 32'h5a5a_5a5a);
    issue(ActDelete, '0);
    issue(ActPushBack, 32'h8000_0000);
    issue(ActPushBack, 32'h7fff_ffff);
    issue(ActPushBack, '0);
    issue(ActPushBack, '1);
    issue(ActPushBack, 32'h7fff_ffff);
    issue(ActDelete, 32'h7fff_ffff);
    issue(ActDelete, 32'h1234_5678);
    issue(ActPopFront, '0);
    issue(ActPopBack, '0);
    for (k = 2; k < DEPTH; k++) issue(ActPushBack, $urandom);
    issue(ActPushBack, 32'h0bad_cafe);
    issue(ActDelete, '1);

    // Random: fill bias changes every 40 commands so the level sweeps empty to full;
    // small values dominate so deletes hit and duplicates occur
    for (n = 0; n < RandomCmds; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 20;
          1:       push_pct = 50;
          2:       push_pct = 75;
          default: push_pct = 90;
        endcase
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct) begin
        act = ActPushBack;
      end else begin
        case ($urandom_range(0, 2))
          0:       act = ActPopFront;
          1:       act = ActPopBack;
          default: act = ActDelete;
        endcase
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        val = $urandom_range(0, 7);
        val = val - 4;
      end else if (sel < 9) begin
        val = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7fff_ffff;
          2:       val = '1;
          default: val = '0;
        endcase
      end
      issue(act, val);
    end
    start_i <= 1'b0;

    // Drain outstanding results, then allow for the registered result strobe
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
sv/dwd_pkg.sv
sv/dwd_cell.sv
sv/deque_with_value_delete.sv
tb/sv/deque_with_value_delete_checker.sv
tb/sv/deque_with_value_delete_tb.sv
